/* hdl/vrp_pkg.sv */
// Shared types, constants and the sine table of the vertex rotate and project block.
package vrp_pkg;

	localparam int SINE_ENTRIES = 256;
	localparam int ANGLE_W = 8;
	localparam int SIN_W = 9;
	localparam int SIN_SHIFT = 8;
	localparam int SIN_ROUND = (1 << SIN_SHIFT) - 1;
	localparam logic [ANGLE_W-1:0] COS_OFFSET = ANGLE_W'(SINE_ENTRIES / 4);

	localparam int DEPTH_W = 12;
	localparam int FOCAL_W = 10;
	localparam int CENTER_W = 10;
	localparam int CFG_DATA_W = 12;
	localparam int OUT_W = 16;

	localparam logic [DEPTH_W-1:0] DEPTH_RST = 12'd150;
	localparam logic [FOCAL_W-1:0] FOCAL_RST = 10'd200;
	localparam logic [CENTER_W-1:0] CX_RST = 10'd160;
	localparam logic [CENTER_W-1:0] CY_RST = 10'd100;

	localparam logic signed [OUT_W-1:0] OUT_MAX = 16'sh7fff;
	localparam logic signed [OUT_W-1:0] OUT_MIN = 16'sh8000;

	typedef enum logic [1:0] {
		CFG_DEPTH,
		CFG_FOCAL,
		CFG_CX,
		CFG_CY
	} cfg_idx_t;

	typedef struct packed {
		logic [DEPTH_W-1:0] depth;
		logic [FOCAL_W-1:0] focal;
		logic [CENTER_W-1:0] cx;
		logic [CENTER_W-1:0] cy;
	} cfg_t;

	localparam logic [7:0] SINE_HALF [SINE_ENTRIES/2] = '{
		8'd0, 8'd6, 8'd12, 8'd18, 8'd25, 8'd31, 8'd37, 8'd43,
		8'd49, 8'd56, 8'd62, 8'd68, 8'd74, 8'd80, 8'd86, 8'd92,
		8'd97, 8'd103, 8'd109, 8'd115, 8'd120, 8'd126, 8'd131, 8'd136,
		8'd142, 8'd147, 8'd152, 8'd157, 8'd162, 8'd167, 8'd171, 8'd176,
		8'd180, 8'd185, 8'd189, 8'd193, 8'd197, 8'd201, 8'd205, 8'd208,
		8'd212, 8'd215, 8'd219, 8'd222, 8'd225, 8'd228, 8'd231, 8'd233,
		8'd236, 8'd238, 8'd240, 8'd242, 8'd244, 8'd246, 8'd247, 8'd249,
		8'd250, 8'd251, 8'd252, 8'd253, 8'd254, 8'd254, 8'd255, 8'd255,
		8'd255, 8'd255, 8'd255, 8'd254, 8'd254, 8'd253, 8'd252, 8'd251,
		8'd250, 8'd249, 8'd247, 8'd246, 8'd244, 8'd242, 8'd240, 8'd238,
		8'd236, 8'd233, 8'd231, 8'd228, 8'd225, 8'd222, 8'd219, 8'd215,
		8'd212, 8'd208, 8'd205, 8'd201, 8'd197, 8'd193, 8'd189, 8'd185,
		8'd180, 8'd176, 8'd171, 8'd167, 8'd162, 8'd157, 8'd152, 8'd147,
		8'd142, 8'd136, 8'd131, 8'd126, 8'd120, 8'd115, 8'd109, 8'd103,
		8'd97, 8'd92, 8'd86, 8'd80, 8'd74, 8'd68, 8'd62, 8'd56,
		8'd49, 8'd43, 8'd37, 8'd31, 8'd25, 8'd18, 8'd12, 8'd6
	};

	// second half of the turn is the negated first half
	function automatic logic signed [SIN_W-1:0] sine(input logic [ANGLE_W-1:0] a);
		logic signed [SIN_W-1:0] m;
		m = $signed({1'b0, SINE_HALF[a[ANGLE_W-2:0]]});
		return a[ANGLE_W-1] ? -m : m;
	endfunction

endpackage

/* hdl/vrp_if.sv */
// Vertex and screen point channel interfaces.
interface vrp_vtx_if #(parameter int COORD_BITS = 12);
	logic valid;
	logic ready;
	logic signed [COORD_BITS-1:0] vertex_x;
	logic signed [COORD_BITS-1:0] vertex_y;
	logic signed [COORD_BITS-1:0] vertex_z;
	logic [vrp_pkg::ANGLE_W-1:0] pitch_angle;
	logic [vrp_pkg::ANGLE_W-1:0] yaw_angle;
	logic [vrp_pkg::ANGLE_W-1:0] roll_angle;
	modport source (output valid, vertex_x, vertex_y, vertex_z, pitch_angle, yaw_angle,
		roll_angle, input ready);
	modport sink (input valid, vertex_x, vertex_y, vertex_z, pitch_angle, yaw_angle,
		roll_angle, output ready);
endinterface

interface vrp_pix_if;
	logic valid;
	logic ready;
	logic signed [vrp_pkg::OUT_W-1:0] screen_x;
	logic signed [vrp_pkg::OUT_W-1:0] screen_y;
	logic point_valid;
	logic clamped;
	modport source (output valid, screen_x, screen_y, point_valid, clamped, input ready);
	modport sink (input valid, screen_x, screen_y, point_valid, clamped, output ready);
endinterface

/* hdl/vertex_rotate_project.sv */
// Path from input accept to output valid: the accept edge loads the front register, then
// the transaction passes the queue, the rotate/multiply stages, the divide stages
// and the output register. Throughput: one transaction per cycle unless out_ch stalls;
// the bit-per-stage divide pipeline sets latency.
// Reset clears all valid state and loads depth 150, focal 200, center 160/100.
// Reset takes effect at once; no clearing pass.
module vertex_rotate_project #(
	parameter int COORD_BITS = 12
) (
	input logic clk,
	input logic arst_n,
	vrp_vtx_if.sink in_ch,
	vrp_pix_if.source out_ch,
	input logic cfg_we,
	input logic [1:0] cfg_idx,
	input logic [vrp_pkg::CFG_DATA_W-1:0] cfg_data
);
	localparam int IW = 3 * COORD_BITS + 6 * vrp_pkg::SIN_W;

	vrp_pkg::cfg_t cfg_q;
	logic push, full, pop, empty;
	logic [IW-1:0] push_data, pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.depth <= vrp_pkg::DEPTH_RST;
			cfg_q.focal <= vrp_pkg::FOCAL_RST;
			cfg_q.cx <= vrp_pkg::CX_RST;
			cfg_q.cy <= vrp_pkg::CY_RST;
		end else if (cfg_we) begin
			case (vrp_pkg::cfg_idx_t'(cfg_idx))
				vrp_pkg::CFG_DEPTH: cfg_q.depth <= cfg_data[vrp_pkg::DEPTH_W-1:0];
				vrp_pkg::CFG_FOCAL: cfg_q.focal <= cfg_data[vrp_pkg::FOCAL_W-1:0];
				vrp_pkg::CFG_CX: cfg_q.cx <= cfg_data[vrp_pkg::CENTER_W-1:0];
				vrp_pkg::CFG_CY: cfg_q.cy <= cfg_data[vrp_pkg::CENTER_W-1:0];
				default: ;
			endcase
		end
	end

	vrp_front #(.COORD_BITS(COORD_BITS), .IW(IW)) u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.push(push), .push_data(push_data), .full(full)
	);

	vrp_fifo #(.W(IW)) u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(push_data), .full(full),
		.pop(pop), .pop_data(pop_data), .empty(empty)
	);

	vrp_back #(.COORD_BITS(COORD_BITS), .IW(IW)) u_back (
		.clk(clk), .arst_n(arst_n), .empty(empty), .pop(pop), .item(pop_data),
		.cfg(cfg_q), .out_ch(out_ch)
	);
endmodule

/* hdl/vrp_fifo.sv */
// Two-entry queue between the front and the back.
module vrp_fifo #(
	parameter int W = 8
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic [W-1:0] push_data,
	output logic full,
	input logic pop,
	output logic [W-1:0] pop_data,
	output logic empty
);
	logic [W-1:0] mem_q [2];
	logic wr_q;
	logic rd_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

/* hdl/vrp_front.sv */
// Front: takes vertex transactions and looks up sine and cosine of each angle.
module vrp_front #(
	parameter int COORD_BITS = 12,
	parameter int IW = 3 * COORD_BITS + 6 * vrp_pkg::SIN_W
) (
	input logic clk,
	input logic arst_n,
	vrp_vtx_if.sink in_ch,
	output logic push,
	output logic [IW-1:0] push_data,
	input logic full
);
	logic vld_s1;
	logic [IW-1:0] item_s1;

	assign in_ch.ready = !vld_s1 || !full;
	assign push = vld_s1 && !full;
	assign push_data = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			vld_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			item_s1 <= {in_ch.vertex_x, in_ch.vertex_y, in_ch.vertex_z,
				vrp_pkg::sine(in_ch.pitch_angle),
				vrp_pkg::sine(in_ch.pitch_angle + vrp_pkg::COS_OFFSET),
				vrp_pkg::sine(in_ch.yaw_angle),
				vrp_pkg::sine(in_ch.yaw_angle + vrp_pkg::COS_OFFSET),
				vrp_pkg::sine(in_ch.roll_angle),
				vrp_pkg::sine(in_ch.roll_angle + vrp_pkg::COS_OFFSET)};
		end
	end
endmodule

/* hdl/vrp_back.sv */
// Back: rotation stages, perspective multiply, pipelined divide and screen offset.
module vrp_back #(
	parameter int COORD_BITS = 12,
	parameter int IW = 3 * COORD_BITS + 6 * vrp_pkg::SIN_W
) (
	input logic clk,
	input logic arst_n,
	input logic empty,
	output logic pop,
	input logic [IW-1:0] item,
	input vrp_pkg::cfg_t cfg,
	vrp_pix_if.source out_ch
);
	localparam int SW = vrp_pkg::SIN_W;
	localparam int RW = COORD_BITS + 3;
	localparam int AW = RW + SW + 1;
	localparam int ZW = ((RW > vrp_pkg::DEPTH_W) ? RW : vrp_pkg::DEPTH_W + 1) + 1;
	localparam int DW = ZW - 1;
	localparam int PW = RW + vrp_pkg::FOCAL_W + 1;
	localparam int NW = PW - 1;
	localparam int QW = NW + 2;

	function automatic logic signed [RW-1:0] rdiv(input logic signed [AW-1:0] s);
		logic signed [AW-1:0] b;
		b = s[AW-1] ? s + AW'(vrp_pkg::SIN_ROUND) : s;
		return RW'(b >>> vrp_pkg::SIN_SHIFT);
	endfunction

	logic signed [COORD_BITS-1:0] ix, iy, iz;
	logic signed [SW-1:0] isx, icx, isy, icy, isz, icz;
	assign {ix, iy, iz, isx, icx, isy, icy, isz, icz} = item;

	logic adv;
	assign adv = !out_ch.valid || out_ch.ready;
	assign pop = adv && !empty;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic signed [RW-1:0] x_s1, y_s1, z_s1, x_s2, y_s2, z_s2, x_s3, y_s3, z_s3;
	logic signed [SW-1:0] sy_s1, cy_s1, sz_s1, cz_s1, sz_s2, cz_s2;
	logic signed [PW-1:0] px_s4, py_s4;
	logic signed [ZW-1:0] zs_s4;

	logic signed [AW-1:0] ax, ay, az;
	always_comb begin
		ax = AW'(iy);
		az = AW'(iz);
	end
	assign ay = '0;

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1 <= RW'(ix);
			y_s1 <= rdiv(ax * AW'(icx) - az * AW'(isx) + ay);
			z_s1 <= rdiv(ax * AW'(isx) + az * AW'(icx));
			sy_s1 <= isy;
			cy_s1 <= icy;
			sz_s1 <= isz;
			cz_s1 <= icz;
			x_s2 <= rdiv(AW'(x_s1) * AW'(cy_s1) + AW'(z_s1) * AW'(sy_s1));
			z_s2 <= rdiv(AW'(z_s1) * AW'(cy_s1) - AW'(x_s1) * AW'(sy_s1));
			y_s2 <= y_s1;
			sz_s2 <= sz_s1;
			cz_s2 <= cz_s1;
			x_s3 <= rdiv(AW'(x_s2) * AW'(cz_s2) - AW'(y_s2) * AW'(sz_s2));
			y_s3 <= rdiv(AW'(x_s2) * AW'(sz_s2) + AW'(y_s2) * AW'(cz_s2));
			z_s3 <= z_s2;
			px_s4 <= PW'(x_s3) * PW'($signed({1'b0, cfg.focal}));
			py_s4 <= PW'(y_s3) * PW'($signed({1'b0, cfg.focal}));
			zs_s4 <= ZW'(z_s3) + ZW'($signed({1'b0, cfg.depth}));
		end
	end

	// divide stages, one quotient bit each; index 0 is the magnitude stage
	logic dv_sn [NW+1];
	logic pos_sn [NW+1];
	logic negx_sn [NW+1];
	logic negy_sn [NW+1];
	logic [DW-1:0] den_sn [NW+1];
	logic [NW-1:0] nx_sn [NW+1];
	logic [NW-1:0] ny_sn [NW+1];
	logic [DW-1:0] rx_sn [NW+1];
	logic [DW-1:0] ry_sn [NW+1];

	assign dv_sn[0] = vld_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_sn[0] <= !zs_s4[ZW-1] && (zs_s4 != '0);
			negx_sn[0] <= px_s4[PW-1];
			negy_sn[0] <= py_s4[PW-1];
			nx_sn[0] <= px_s4[PW-1] ? NW'(-px_s4) : NW'(px_s4);
			ny_sn[0] <= py_s4[PW-1] ? NW'(-py_s4) : NW'(py_s4);
			den_sn[0] <= zs_s4[DW-1:0];
			rx_sn[0] <= '0;
			ry_sn[0] <= '0;
		end
	end

	for (genvar k = 0; k < NW; k++) begin : g_div
		logic [DW:0] tx, ty, dx, dy;
		logic gx, gy;
		always_comb begin
			tx = {rx_sn[k], nx_sn[k][NW-1]};
			ty = {ry_sn[k], ny_sn[k][NW-1]};
			dx = tx - {1'b0, den_sn[k]};
			dy = ty - {1'b0, den_sn[k]};
			gx = tx >= {1'b0, den_sn[k]};
			gy = ty >= {1'b0, den_sn[k]};
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				rx_sn[k+1] <= gx ? dx[DW-1:0] : tx[DW-1:0];
				ry_sn[k+1] <= gy ? dy[DW-1:0] : ty[DW-1:0];
				nx_sn[k+1] <= {nx_sn[k][NW-2:0], gx};
				ny_sn[k+1] <= {ny_sn[k][NW-2:0], gy};
				den_sn[k+1] <= den_sn[k];
				pos_sn[k+1] <= pos_sn[k];
				negx_sn[k+1] <= negx_sn[k];
				negy_sn[k+1] <= negy_sn[k];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_sn[k+1] <= 1'b0;
			else if (adv) dv_sn[k+1] <= dv_sn[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			out_ch.valid <= 1'b0;
		end else if (adv) begin
			vld_s1 <= !empty;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			out_ch.valid <= dv_sn[NW];
		end
	end

	logic signed [QW-1:0] qx, qy, vx, vy;
	logic hx_lo, hx_hi, hy_lo, hy_hi;
	always_comb begin
		qx = $signed({2'b00, nx_sn[NW]});
		qy = $signed({2'b00, ny_sn[NW]});
		vx = (negx_sn[NW] ? -qx : qx) + QW'($signed({1'b0, cfg.cx}));
		vy = (negy_sn[NW] ? -qy : qy) + QW'($signed({1'b0, cfg.cy}));
		hx_hi = vx > QW'(vrp_pkg::OUT_MAX);
		hx_lo = vx < QW'(vrp_pkg::OUT_MIN);
		hy_hi = vy > QW'(vrp_pkg::OUT_MAX);
		hy_lo = vy < QW'(vrp_pkg::OUT_MIN);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (!pos_sn[NW]) begin
				out_ch.screen_x <= '0;
				out_ch.screen_y <= '0;
				out_ch.point_valid <= 1'b0;
				out_ch.clamped <= 1'b0;
			end else begin
				out_ch.screen_x <= hx_hi ? vrp_pkg::OUT_MAX :
					hx_lo ? vrp_pkg::OUT_MIN : vx[vrp_pkg::OUT_W-1:0];
				out_ch.screen_y <= hy_hi ? vrp_pkg::OUT_MAX :
					hy_lo ? vrp_pkg::OUT_MIN : vy[vrp_pkg::OUT_W-1:0];
				out_ch.point_valid <= 1'b1;
				out_ch.clamped <= hx_hi || hx_lo || hy_hi || hy_lo;
			end
		end
	end

	a_behind_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.point_valid |->
			out_ch.screen_x == '0 && out_ch.screen_y == '0 && !out_ch.clamped)
		else $error("point behind viewer with nonzero fields");

	a_clamp_rail: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.clamped |->
			out_ch.screen_x == vrp_pkg::OUT_MAX || out_ch.screen_x == vrp_pkg::OUT_MIN ||
			out_ch.screen_y == vrp_pkg::OUT_MAX || out_ch.screen_y == vrp_pkg::OUT_MIN)
		else $error("clamped flag without a saturated coordinate");

	a_pop_enters: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> vld_s1)
		else $error("popped transaction lost before first stage");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> vld_s5 == $past(vld_s5) && dv_sn[NW] == $past(dv_sn[NW]))
		else $error("pipeline moved while output stalled");
endmodule
